// ===== sv/tve_pkg.sv =====
// ----------------------------------------------------------------------------
// tve_pkg: shared types and constants of the tracker voice effect engine
// Amiga period table, request and event codes, divider width.
// ----------------------------------------------------------------------------
package tve_pkg;

    localparam int DIV_W = 21;   // |tune| * 32 fits in 21 bits

    typedef enum logic [1:0] {
        K_NEW_EFFECT = 2'd0,
        K_START_NOTE = 2'd1,
        K_TICK       = 2'd2,
        K_UNUSED     = 2'd3
    } t_req_kind;

    typedef enum logic [2:0] {
        EV_NOTE_OFF   = 3'd0,
        EV_NOTE_ON    = 3'd1,
        EV_OFFSET     = 3'd2,
        EV_EXPRESSION = 3'd3,
        EV_PITCH      = 3'd4
    } t_ev_kind;

    localparam logic [3:0] FX_PORTA     = 4'd3;
    localparam logic [3:0] FX_OFFSET    = 4'd9;
    localparam logic [3:0] FX_VOL_SLIDE = 4'd10;
    localparam logic [3:0] FX_SET_VOL   = 4'd12;

    localparam logic [7:0]  NOTE_NONE  = 8'd255;
    localparam logic [5:0]  TAB_LAST   = 6'd59;
    localparam logic [11:0] PERIOD_MIN = 12'd56;
    localparam logic [11:0] PERIOD_MAX = 12'd1712;

    function automatic logic [10:0] period_at(input logic [5:0] idx);
        logic [10:0] p;
        case (idx)
            6'd0: p = 11'd1712;  6'd1: p = 11'd1616;  6'd2: p = 11'd1524;
            6'd3: p = 11'd1440;  6'd4: p = 11'd1356;  6'd5: p = 11'd1280;
            6'd6: p = 11'd1208;  6'd7: p = 11'd1140;  6'd8: p = 11'd1076;
            6'd9: p = 11'd1016;  6'd10: p = 11'd960;  6'd11: p = 11'd906;
            6'd12: p = 11'd856;  6'd13: p = 11'd808;  6'd14: p = 11'd762;
            6'd15: p = 11'd720;  6'd16: p = 11'd678;  6'd17: p = 11'd640;
            6'd18: p = 11'd604;  6'd19: p = 11'd570;  6'd20: p = 11'd538;
            6'd21: p = 11'd508;  6'd22: p = 11'd480;  6'd23: p = 11'd453;
            6'd24: p = 11'd428;  6'd25: p = 11'd404;  6'd26: p = 11'd381;
            6'd27: p = 11'd360;  6'd28: p = 11'd339;  6'd29: p = 11'd320;
            6'd30: p = 11'd302;  6'd31: p = 11'd285;  6'd32: p = 11'd269;
            6'd33: p = 11'd254;  6'd34: p = 11'd240;  6'd35: p = 11'd226;
            6'd36: p = 11'd214;  6'd37: p = 11'd202;  6'd38: p = 11'd190;
            6'd39: p = 11'd180;  6'd40: p = 11'd170;  6'd41: p = 11'd160;
            6'd42: p = 11'd151;  6'd43: p = 11'd143;  6'd44: p = 11'd135;
            6'd45: p = 11'd127;  6'd46: p = 11'd120;  6'd47: p = 11'd113;
            6'd48: p = 11'd107;  6'd49: p = 11'd101;  6'd50: p = 11'd95;
            6'd51: p = 11'd90;   6'd52: p = 11'd85;   6'd53: p = 11'd80;
            6'd54: p = 11'd75;   6'd55: p = 11'd71;   6'd56: p = 11'd67;
            6'd57: p = 11'd63;   6'd58: p = 11'd60;   6'd59: p = 11'd56;
            default: p = 11'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== sv/tve_div.sv =====
// ----------------------------------------------------------------------------
// tve_div: shared restoring divider
// Unsigned quotient, one bit per cycle, done pulses when the last bit is in.
// ----------------------------------------------------------------------------
module tve_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tve_pkg::DIV_W-1:0] i_num,
    input  logic [6:0]                i_den,
    output logic                      o_done,
    output logic [tve_pkg::DIV_W-1:0] o_quo
);
    import tve_pkg::*;

    logic [DIV_W-1:0] r_q;
    logic [6:0]       r_rem;
    logic [6:0]       r_den;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [7:0]       w_sh;
    logic             w_ge;

    assign w_sh = {r_rem, r_q[DIV_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= 5'(DIV_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? 7'(w_sh - {1'b0, r_den}) : w_sh[6:0];
                r_q   <= {r_q[DIV_W-2:0], w_ge};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

// ===== sv/tracker_voice_effect_engine.sv =====
// ----------------------------------------------------------------------------
// tracker_voice_effect_engine: per-voice tracker effects to note events
// Portamento, volume slides, sample offsets and pitch bend per voice.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: tuser = kind (new effect, start note, tick);
//   tdata = voice, period, effect, arg, ticks, sample_number, event_time.
//   m_axis returns 0..4 events per request: tuser = event kind, tlast marks
//   the final event of the request; tdata = channel, data_a, data_b, stamp.
//   Config port i_cfg_*: index 0 note_offset, index 1 bend_sensitivity;
//   write only while idle.
// Sequencing:
//   New effect: voice state update only. Tick volume slide: one slide step
//   per tick, then a report and the drain. Period mapping takes a 6-step
//   table search, and a fine tune adds one pass of the shared divider; a
//   pitch event another pass.
//   One request is worked at a time; s_axis_tready is low meanwhile.
// Reset: every voice silent (note none), all voice state zero,
//   note_offset 24, bend_sensitivity 2.
// Stall: events wait in a 4-entry list and one output register; a stalled
//   receiver holds the engine in its drain state.
// ----------------------------------------------------------------------------
module tracker_voice_effect_engine #(
    parameter int VOICES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // voice[4:0] period[16:5] effect[20:17] arg[28:21] ticks[34:29]
    // sample_number[39:35] event_time[71:40]
    input  logic [71:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // channel[5:0] data_a[13:6] data_b[21:14] stamp[53:22] zero[55:54]
    output logic [55:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // event_kind[2:0]
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    import tve_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic REG_NOTE_OFFSET = 1'b0;
    localparam logic REG_BEND_SENS   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_PORTA, S_SEARCH, S_FINE, S_FWAIT, S_NOTE,
        S_PITCH, S_DIVW, S_VSLIDE, S_VREPORT, S_DRAIN
    } t_state;

    // config
    logic [6:0] r_note_offset, r_bend_sens;

    // request
    t_state     r_state;
    logic [1:0] r_kind;
    logic [4:0] r_voice;
    logic [11:0] r_per;
    logic [3:0] r_eff;
    logic [7:0] r_arg;
    logic [5:0] r_ticks;
    logic [4:0] r_smp;
    logic [31:0] r_time;

    // voice state
    logic [7:0]         r_snote [VOICES];
    logic [11:0]        r_cur   [VOICES];
    logic [11:0]        r_tgt   [VOICES];
    logic [7:0]         r_step  [VOICES];
    logic [6:0]         r_vol   [VOICES];
    logic [6:0]         r_rvol  [VOICES];
    logic signed [15:0] r_btune [VOICES];
    logic [7:0]         r_ofine [VOICES];
    logic [7:0]         r_appl  [VOICES];   // offset high byte, low byte is 0
    logic [7:0]         r_pend  [VOICES];
    logic [3:0]         r_aeff  [VOICES];
    logic [7:0]         r_aarg  [VOICES];

    // work registers
    logic [13:0]        r_d;
    logic [11:0]        r_mp;
    logic [5:0]         r_n;
    logic [5:0]         r_sbit;
    logic [7:0]         r_fine;
    logic               r_from_start;
    logic signed [17:0] r_tune;
    logic               r_neg;
    logic [5:0]         r_cnt;

    // event list
    logic [2:0] r_ev_kind [4];
    logic [5:0] r_ev_ch   [4];
    logic [7:0] r_ev_a    [4];
    logic [7:0] r_ev_b    [4];
    logic [2:0] r_ev_cnt;
    logic [2:0] r_drain;

    // output register
    logic        r_mvalid;
    logic [55:0] r_mdata;
    logic [2:0]  r_muser;
    logic        r_mlast;

    // divider
    logic             r_div_start;
    logic [DIV_W-1:0] r_div_num;
    logic [6:0]       r_div_den;
    logic             w_div_done;
    logic [DIV_W-1:0] w_div_quo;

    tve_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    function automatic logic [6:0] vol_slide(input logic [6:0] vol, input logic [7:0] arg);
        logic signed [8:0] t;
        t = $signed({2'b0, vol}) + $signed({5'b0, arg[7:4]}) - $signed({5'b0, arg[3:0]});
        if (t < 0)        return 7'd0;
        else if (t > 64)  return 7'd64;
        else              return t[6:0];
    endfunction

    wire [VW-1:0] v = r_voice[VW-1:0];
    wire          w_accept = s_axis_tvalid && s_axis_tready;
    wire          w_out_free = !r_mvalid || m_axis_tready;

    // search and fine-tune datapath
    logic [6:0]  w_cand;
    logic [10:0] w_cand_p, w_tn, w_tn1;
    logic [7:0]  w_note;
    logic [11:0] w_vnext;
    logic signed [15:0] w_pi;
    logic signed [15:0] w_tsat;
    logic [15:0] w_tmag;
    logic signed [22:0] w_bend;
    logic [13:0] w_bclamp;
    logic [6:0]  w_expr;

    always_comb begin
        w_cand   = {1'b0, r_n} + {1'b0, r_sbit};
        w_cand_p = period_at(w_cand[5:0]);
        w_tn     = period_at(r_n);
        w_tn1    = period_at(6'(r_n + 6'd1));
        w_note   = 8'({2'b0, r_n} + {1'b0, r_note_offset});
        // portamento step, period plus step reaches 20160
        if (r_cur[v] > r_tgt[v]) begin
            w_pi = $signed({4'b0, r_cur[v]}) - $signed({2'b0, r_d});
            if (w_pi < $signed({4'b0, r_tgt[v]})) w_pi = $signed({4'b0, r_tgt[v]});
        end else begin
            w_pi = $signed({4'b0, r_cur[v]}) + $signed({2'b0, r_d});
            if (w_pi > $signed({4'b0, r_tgt[v]})) w_pi = $signed({4'b0, r_tgt[v]});
        end
        // tune saturation
        if (r_tune > 18'sd32767)       w_tsat = 16'sd32767;
        else if (r_tune < -18'sd32768) w_tsat = -16'sd32768;
        else                           w_tsat = r_tune[15:0];
        w_tmag = w_tsat[15] ? 16'(-{w_tsat[15], w_tsat}) : w_tsat;
        // bend
        w_bend = r_neg ? 23'sd8192 - $signed({2'b0, w_div_quo})
                       : 23'sd8192 + $signed({2'b0, w_div_quo});
        if (w_bend <= 0)           w_bclamp = 14'd1;
        else if (w_bend >= 16384)  w_bclamp = 14'd16383;
        else                       w_bclamp = w_bend[13:0];
        w_vnext = {5'b0, vol_slide(r_vol[v], r_aarg[v])};
        w_expr  = (r_vol[v] >= 7'd64) ? 7'd127 : 7'({r_vol[v], 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_note_offset <= 7'd24;
            r_bend_sens   <= 7'd2;
            r_ev_cnt      <= '0;
            r_drain       <= '0;
            r_mvalid      <= 1'b0;
            r_div_start   <= 1'b0;
            for (int i = 0; i < VOICES; i++) begin
                r_snote[i] <= NOTE_NONE;
                r_cur[i]   <= '0;
                r_tgt[i]   <= '0;
                r_step[i]  <= '0;
                r_vol[i]   <= '0;
                r_rvol[i]  <= '0;
                r_btune[i] <= '0;
                r_ofine[i] <= '0;
                r_appl[i]  <= '0;
                r_pend[i]  <= '0;
                r_aeff[i]  <= '0;
                r_aarg[i]  <= '0;
            end
        end else begin
            // a drain step with a free output loads the register instead
            if (m_axis_tready && !(r_state == S_DRAIN && r_drain != r_ev_cnt))
                r_mvalid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_NOTE_OFFSET: r_note_offset <= i_cfg_data;
                    REG_BEND_SENS:   r_bend_sens   <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind   <= s_axis_tuser;
                        r_voice  <= s_axis_tdata[4:0];
                        r_per    <= s_axis_tdata[16:5];
                        r_eff    <= s_axis_tdata[20:17];
                        r_arg    <= s_axis_tdata[28:21];
                        r_ticks  <= s_axis_tdata[34:29];
                        r_smp    <= s_axis_tdata[39:35];
                        r_time   <= s_axis_tdata[71:40];
                        r_ev_cnt <= '0;
                        r_drain  <= '0;
                        if (32'(s_axis_tdata[4:0]) < VOICES) r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_kind)
                        K_NEW_EFFECT: begin
                            r_state   <= S_IDLE;
                            // portamento without a sounding note is dropped
                            r_aeff[v] <= (r_eff == FX_PORTA && r_snote[v] == NOTE_NONE)
                                         ? 4'd0 : r_eff;
                            r_aarg[v] <= r_arg;
                            if (r_eff == FX_PORTA) begin
                                if (r_snote[v] != NOTE_NONE) begin
                                    if (r_arg != 8'd0) r_step[v] <= r_arg;
                                    if (r_per != 12'd0) r_tgt[v] <= r_per;
                                end
                            end else if (r_eff == FX_OFFSET) begin
                                r_pend[v] <= r_arg;
                            end else if (r_eff == FX_VOL_SLIDE) begin
                                r_vol[v] <= vol_slide(r_vol[v], r_arg);
                            end else if (r_eff == FX_SET_VOL) begin
                                r_vol[v] <= {1'b0, r_arg[5:0]};
                            end
                        end
                        K_START_NOTE: begin
                            logic [2:0] c;
                            c = 3'd0;
                            if (r_snote[v] != NOTE_NONE) begin
                                r_ev_kind[0] <= EV_NOTE_OFF;
                                r_ev_ch[0]   <= {1'b0, r_voice};
                                r_ev_a[0]    <= r_snote[v];
                                r_ev_b[0]    <= 8'd0;
                                c = 3'd1;
                            end
                            if (r_appl[v] != r_pend[v]) begin
                                r_appl[v]          <= r_pend[v];
                                r_ev_kind[c[1:0]]  <= EV_OFFSET;
                                r_ev_ch[c[1:0]]    <= {1'b0, r_smp} + 6'd1;
                                r_ev_a[c[1:0]]     <= 8'd0;
                                r_ev_b[c[1:0]]     <= r_pend[v];
                                c = c + 3'd1;
                            end
                            r_ev_cnt     <= c;
                            r_from_start <= 1'b1;
                            if (r_per >= PERIOD_MIN && r_per <= PERIOD_MAX) begin
                                r_mp    <= r_per;
                                r_n     <= '0;
                                r_sbit  <= 6'd32;
                                r_state <= S_SEARCH;
                            end else begin
                                r_snote[v] <= NOTE_NONE;
                                r_ofine[v] <= '0;
                                r_tune     <= '0;
                                r_state    <= S_PITCH;
                            end
                        end
                        K_TICK: begin
                            if (r_aeff[v] == FX_PORTA) begin
                                r_d     <= r_step[v] * r_ticks;
                                r_state <= S_PORTA;
                            end else if (r_aeff[v] == FX_VOL_SLIDE) begin
                                r_cnt   <= '0;
                                r_state <= S_VSLIDE;
                            end else begin
                                r_state <= S_DRAIN;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_PORTA: begin
                    r_from_start <= 1'b0;
                    if (r_cur[v] != r_tgt[v] && w_pi[11:0] != r_cur[v] &&
                        r_snote[v] != NOTE_NONE) begin
                        r_cur[v] <= w_pi[11:0];
                        if (w_pi[11:0] >= PERIOD_MIN && w_pi[11:0] <= PERIOD_MAX) begin
                            r_mp    <= w_pi[11:0];
                            r_n     <= '0;
                            r_sbit  <= 6'd32;
                            r_state <= S_SEARCH;
                        end else begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_SEARCH: begin
                    // last table entry still >= period
                    if (w_cand < 7'd60 && {1'b0, w_cand_p} >= r_mp) r_n <= w_cand[5:0];
                    r_sbit <= r_sbit >> 1;
                    if (r_sbit == 6'd1) r_state <= S_FINE;
                end
                S_FINE: begin
                    if ({1'b0, w_tn} != r_mp && r_n != TAB_LAST) begin
                        r_div_num   <= DIV_W'({w_tn - r_mp[10:0], 8'd0});
                        r_div_den   <= 7'(w_tn - w_tn1);
                        r_div_start <= 1'b1;
                        r_state     <= S_FWAIT;
                    end else begin
                        r_fine  <= '0;
                        r_state <= S_NOTE;
                    end
                end
                S_FWAIT: begin
                    r_div_start <= 1'b0;
                    if (w_div_done) begin
                        r_fine  <= w_div_quo[7:0];
                        r_state <= S_NOTE;
                    end
                end
                S_NOTE: begin
                    r_state <= S_PITCH;
                    if (r_from_start) begin
                        r_snote[v]              <= w_note;
                        r_cur[v]                <= r_per;
                        r_ofine[v]              <= r_fine;
                        r_ev_kind[r_ev_cnt[1:0]] <= EV_NOTE_ON;
                        r_ev_ch[r_ev_cnt[1:0]]   <= {1'b0, r_voice};
                        r_ev_a[r_ev_cnt[1:0]]    <= w_note;
                        r_ev_b[r_ev_cnt[1:0]]    <= 8'd127;
                        r_ev_cnt                 <= r_ev_cnt + 3'd1;
                        r_tune                   <= {10'b0, r_fine};
                    end else begin
                        r_tune <= $signed({2'b0, w_note, r_fine}) -
                                  $signed({2'b0, r_snote[v], r_ofine[v]});
                    end
                end
                S_PITCH: begin
                    if (w_tsat == r_btune[v]) r_state <= S_DRAIN;
                    else begin
                        r_btune[v]  <= w_tsat;
                        r_neg       <= w_tsat[15];
                        r_div_num   <= DIV_W'({w_tmag, 5'b0});
                        r_div_den   <= (r_bend_sens == 7'd0) ? 7'd1 : r_bend_sens;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    r_div_start <= 1'b0;
                    if (w_div_done) begin
                        r_ev_kind[r_ev_cnt[1:0]] <= EV_PITCH;
                        r_ev_ch[r_ev_cnt[1:0]]   <= {1'b0, r_voice};
                        r_ev_a[r_ev_cnt[1:0]]    <= {1'b0, w_bclamp[6:0]};
                        r_ev_b[r_ev_cnt[1:0]]    <= {1'b0, w_bclamp[13:7]};
                        r_ev_cnt                 <= r_ev_cnt + 3'd1;
                        r_state                  <= S_DRAIN;
                    end
                end
                S_VSLIDE: begin
                    if (r_cnt == r_ticks) r_state <= S_VREPORT;
                    else begin
                        r_vol[v] <= w_vnext[6:0];
                        r_cnt    <= r_cnt + 6'd1;
                    end
                end
                S_VREPORT: begin
                    r_state <= S_DRAIN;
                    if (r_rvol[v] != r_vol[v]) begin
                        r_rvol[v]    <= r_vol[v];
                        r_ev_kind[0] <= EV_EXPRESSION;
                        r_ev_ch[0]   <= {1'b0, r_voice};
                        r_ev_a[0]    <= {1'b0, w_expr};
                        r_ev_b[0]    <= 8'd0;
                        r_ev_cnt     <= 3'd1;
                    end
                end
                S_DRAIN: begin
                    if (r_drain == r_ev_cnt) r_state <= S_IDLE;
                    else if (w_out_free) begin
                        r_mvalid <= 1'b1;
                        r_muser  <= r_ev_kind[r_drain[1:0]];
                        r_mdata  <= {2'b0, r_time, r_ev_b[r_drain[1:0]],
                                     r_ev_a[r_drain[1:0]], r_ev_ch[r_drain[1:0]]};
                        r_mlast  <= (r_drain + 3'd1 == r_ev_cnt);
                        r_drain  <= r_drain + 3'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;
    assign m_axis_tlast  = r_mlast;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("engine took a request while busy");
    a_ev_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_cnt <= 3'd4)
        else $error("event list overflow");
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_FWAIT || r_state == S_DIVW))
        else $error("divider finished with no waiting state");
`endif
endmodule
